[rtl/csvfs_pkg.sv]
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV line field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_CAP = 1'b1;

  localparam logic [7:0]  SEPARATOR_RST = 8'd44;
  localparam logic [10:0] FIELD_CAP_RST = 11'd1024;

  // one result beat
  typedef struct packed {
    logic [31:0] start_offset;
    logic [31:0] field_length;
    logic        has_doubled_quote;
    logic [9:0]  field_number;
    logic        descriptor_valid;
    logic        line_end;
    logic [10:0] fields_recorded;
  } res_t;

  // results produced by one parsed byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res1;
    res_t       res0;
  } push_t;

endpackage

`default_nettype wire

[rtl/csv_line_field_splitter_core.sv]
// ----------------------------------------------------------------------------
// csv_line_field_splitter_core
// Scans CSV text one byte per beat and emits one descriptor per field.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | text_byte, first_byte, line_offset,
//          |           |                    | end_of_data
//  out_    | output    | out_valid/out_stall| field descriptor, line_end, count
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while in_stall is low.
// A byte giving two results (separator as last byte) yields two result beats.
// Input register feeds the parser, which writes a 4-entry result buffer;
// in_stall rises only when that buffer has fewer than two free slots.
// Synchronous active-low reset; parser idles until a first_byte beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_field_splitter_core
  import csvfs_pkg::*;
#(
  parameter int unsigned POS_WIDTH       = 32,
  parameter int unsigned MAX_FIELD_COUNT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_first_byte,
  input  wire logic [31:0]           in_line_offset,
  input  wire logic                  in_end_of_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_start_offset,
  output logic [31:0]                out_field_length,
  output logic                       out_has_doubled_quote,
  output logic [9:0]                 out_field_number,
  output logic                       out_descriptor_valid,
  output logic                       out_line_end,
  output logic [10:0]                out_fields_recorded,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        first_r;
  logic [31:0] offset_r;
  logic        eod_r;
  logic [7:0]  sep_r;
  logic [10:0] cap_r;
  logic        room;
  logic        fire;
  push_t       push;
  res_t        head;

  assign cfg_ready = 1'b1;
  assign fire      = vld_r && room;
  assign in_stall  = vld_r && !room;
  assign vld_nxt   = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sep_r <= SEPARATOR_RST;
      cap_r <= FIELD_CAP_RST;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEPARATOR: sep_r <= cfg_data[7:0];
          REG_FIELD_CAP: cap_r <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r   <= in_text_byte;
      first_r  <= in_first_byte;
      offset_r <= in_line_offset;
      eod_r    <= in_end_of_data;
    end
  end

  csvfs_parser #(
    .POS_WIDTH       (POS_WIDTH),
    .MAX_FIELD_COUNT (MAX_FIELD_COUNT)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .text_byte      (byte_r),
    .first_byte     (first_r),
    .line_offset    (offset_r),
    .end_of_data    (eod_r),
    .separator_char (sep_r),
    .field_cap      (cap_r),
    .push           (push)
  );

  csvfs_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_start_offset      = head.start_offset;
  assign out_field_length      = head.field_length;
  assign out_has_doubled_quote = head.has_doubled_quote;
  assign out_field_number      = head.field_number;
  assign out_descriptor_valid  = head.descriptor_valid;
  assign out_line_end          = head.line_end;
  assign out_fields_recorded   = head.fields_recorded;

endmodule

`default_nettype wire

[rtl/csvfs_parser.sv]
// ----------------------------------------------------------------------------
// csvfs_parser
// Quote/separator state machine; turns one byte into zero, one or two
// field descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_parser
  import csvfs_pkg::*;
#(
  parameter int unsigned POS_WIDTH       = 32,
  parameter int unsigned MAX_FIELD_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic [7:0]  text_byte,
  input  wire logic        first_byte,
  input  wire logic [31:0] line_offset,
  input  wire logic        end_of_data,
  input  wire logic [7:0]  separator_char,
  input  wire logic [10:0] field_cap,
  output push_t            push
);

  localparam int unsigned CNT_W = $clog2(MAX_FIELD_COUNT + 1);
  localparam int unsigned CMP_W = (CNT_W > 11) ? CNT_W : 11;

  logic                 iq_r, iq_nxt;
  logic                 qs_r, qs_nxt;
  logic                 dq_r, dq_nxt;
  logic                 fin_r, fin_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] begin_r, begin_nxt;
  logic [CNT_W-1:0]     rec_r, rec_nxt;
  logic [9:0]           idx_r, idx_nxt;

  logic [POS_WIDTH-1:0] cur_pos;
  logic [POS_WIDTH-1:0] end_pos;
  logic [CMP_W-1:0]     cap_eff;
  logic                 run;
  logic                 consumed;
  logic                 ended;

  // descriptor for the current field; cap_ok tells whether it is recorded
  function automatic res_t build_res(input logic [POS_WIDTH-1:0] fbeg,
                                     input logic [POS_WIDTH-1:0] fend,
                                     input logic                 dq,
                                     input logic                 cap_ok,
                                     input logic [CNT_W-1:0]     rec,
                                     input logic [9:0]           idx,
                                     input logic                 last);
    res_t                 r;
    logic [POS_WIDTH-1:0] len;
    logic [CNT_W-1:0]     rec_after;
    r         = '0;
    len       = fend - fbeg;
    rec_after = cap_ok ? rec + CNT_W'(1) : rec;
    if (cap_ok) begin
      r.start_offset      = 32'(fbeg);
      r.field_length      = 32'(len);
      r.has_doubled_quote = dq;
      r.descriptor_valid  = 1'b1;
    end
    r.field_number    = idx;
    r.line_end        = last;
    r.fields_recorded = last ? 11'(rec_after) : 11'd0;
    return r;
  endfunction

  always_comb begin
    cap_eff = CMP_W'(field_cap);
    if (cap_eff > CMP_W'(MAX_FIELD_COUNT)) begin
      cap_eff = CMP_W'(MAX_FIELD_COUNT);
    end
  end

  always_comb begin
    iq_nxt    = iq_r;
    qs_nxt    = qs_r;
    dq_nxt    = dq_r;
    fin_nxt   = fin_r;
    pos_nxt   = pos_r;
    begin_nxt = begin_r;
    rec_nxt   = rec_r;
    idx_nxt   = idx_r;
    cur_pos   = '0;
    end_pos   = '0;
    run       = 1'b0;
    consumed  = 1'b0;
    ended     = 1'b0;
    push      = '0;
    if (fire) begin
      run = 1'b1;
      if (first_byte) begin
        pos_nxt   = POS_WIDTH'(line_offset);
        begin_nxt = POS_WIDTH'(line_offset);
        iq_nxt    = 1'b0;
        qs_nxt    = 1'b0;
        dq_nxt    = 1'b0;
        rec_nxt   = '0;
        idx_nxt   = '0;
        fin_nxt   = 1'b0;
      end else if (fin_r) begin
        run = 1'b0;
      end
    end

    if (run) begin
      cur_pos = pos_nxt;
      pos_nxt = cur_pos + POS_WIDTH'(1);

      if (iq_nxt) begin
        if (qs_nxt) begin
          qs_nxt = 1'b0;
          if (text_byte == QUOTE_BYTE) begin
            dq_nxt   = 1'b1;
            consumed = 1'b1;
          end else begin
            iq_nxt = 1'b0;
          end
        end else begin
          if (text_byte == QUOTE_BYTE) begin
            qs_nxt = 1'b1;
          end
          consumed = 1'b1;
        end
      end

      if (!consumed) begin
        if (text_byte == QUOTE_BYTE) begin
          iq_nxt = 1'b1;
        end else if (text_byte == separator_char) begin
          push.res0 = build_res(begin_nxt, cur_pos, dq_nxt,
                                CMP_W'(rec_nxt) < cap_eff, rec_nxt, idx_nxt, 1'b0);
          push.cnt  = 2'd1;
          if (CMP_W'(rec_nxt) < cap_eff) begin
            rec_nxt = rec_nxt + CNT_W'(1);
          end
          idx_nxt   = idx_nxt + 10'd1;
          begin_nxt = cur_pos + POS_WIDTH'(1);
          dq_nxt    = 1'b0;
        end else if (text_byte == NEWLINE_BYTE) begin
          ended   = 1'b1;
          end_pos = cur_pos;
        end
      end

      if (!ended && end_of_data) begin
        ended   = 1'b1;
        end_pos = cur_pos + POS_WIDTH'(1);
      end

      if (ended) begin
        // final descriptor goes after the separator one, if any
        if (push.cnt == 2'd0) begin
          push.res0 = build_res(begin_nxt, end_pos, dq_nxt,
                                CMP_W'(rec_nxt) < cap_eff, rec_nxt, idx_nxt, 1'b1);
        end else begin
          push.res1 = build_res(begin_nxt, end_pos, dq_nxt,
                                CMP_W'(rec_nxt) < cap_eff, rec_nxt, idx_nxt, 1'b1);
        end
        push.cnt = push.cnt + 2'd1;
        if (CMP_W'(rec_nxt) < cap_eff) begin
          rec_nxt = rec_nxt + CNT_W'(1);
        end
        idx_nxt = idx_nxt + 10'd1;
        fin_nxt = 1'b1;
        iq_nxt  = 1'b0;
        qs_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r    <= 1'b0;
      qs_r    <= 1'b0;
      dq_r    <= 1'b0;
      fin_r   <= 1'b1;
      pos_r   <= '0;
      begin_r <= '0;
      rec_r   <= '0;
      idx_r   <= '0;
    end else begin
      iq_r    <= iq_nxt;
      qs_r    <= qs_nxt;
      dq_r    <= dq_nxt;
      fin_r   <= fin_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      rec_r   <= rec_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/csvfs_result_queue.sv]
// ----------------------------------------------------------------------------
// csvfs_result_queue
// Four-entry result buffer; takes up to two beats per cycle, gives one while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_result_queue
  import csvfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_stall,
  output res_t       head
);

  localparam int unsigned DEPTH = 4;

  res_t       mem_r [DEPTH];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  // two free slots guaranteed before a byte is parsed
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push.cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
